FILE: hdl/reed_pkg.sv
// Shared types and constants for the rotary encoder event decoder.
// Holds the quadrature step table, event codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package reed_pkg;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_SHORT = 3'd3,
        EV_LONG  = 3'd4
    } event_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEBOUNCE_MS      = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS_MS    = 2'd1;
    localparam logic [1:0] CFG_STEPS_PER_DETENT = 2'd2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [9:0]  DEBOUNCE_RST   = 10'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [4:0]  STEPS_RST      = 5'd4;

    // Bit positions in the input request word.
    localparam int IN_PIN_A  = 0;
    localparam int IN_PIN_B  = 1;
    localparam int IN_BUTTON = 2;
    localparam int IN_TICK   = 3;
    localparam int IN_QUERY  = 4;

    // Quadrature step for the pair {old A, old B, new A, new B}: +1, -1 or 0.
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default:                  d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hdl/rotary_encoder_event_decoder.sv
// Rotary encoder event decoder: quadrature counting plus a debounced push button.
// Depends on reed_pkg for the step table, event codes and register indexes.
`timescale 1ns / 1ps

// Channel   | Direction | Width | Contents (lowest bit first)
// ----------+-----------+-------+--------------------------------------------------
// s_axis    | in        | 8     | pin_a, pin_b, button_level, ms_tick, query, 0 pad
// m_axis    | out       | 8     | event_code[2:0], button_held, 0 pad
// cfg       | in        | 16    | write of debounce_ms, long_press_ms, steps_per_detent
//
// Each request is evaluated in the cycle it is accepted; its result appears in the
// output register on the next cycle. One request per cycle is sustained while results
// are taken, set by the single result register with pass-through ready.
// Reset (aresetn low, synchronous) clears all encoder and button state, empties
// the output register and restores the register defaults.
// While the output register holds an untaken result, a new request is accepted only
// in a cycle where that result is taken at the same edge.

module rotary_encoder_event_decoder #(
    parameter int BALANCE_BITS = 8,
    parameter int TIME_BITS    = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input requests.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // pin_a, pin_b, button_level, ms_tick, query
    // Results.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // event_code[2:0], button_held
    // Register writes.
    input  logic                             cfg_wr_en,
    input  logic [reed_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [reed_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic signed [BALANCE_BITS:0] BAL_MAX =
        $signed((BALANCE_BITS+1)'((1 << (BALANCE_BITS-1)) - 1));
    localparam logic signed [BALANCE_BITS:0] BAL_MIN = -BAL_MAX - 1;

    // Configuration registers.
    logic [9:0]  debounce_reg;
    logic [15:0] long_press_reg;
    logic [4:0]  steps_reg;

    // Decoder state.
    logic [1:0]                     prev_ab_reg, prev_ab_next;
    logic                           ab_loaded_reg, ab_loaded_next;
    logic signed [BALANCE_BITS-1:0] balance_reg, balance_next;
    logic                           raw_prev_reg, raw_prev_next;
    logic                           stable_reg, stable_next;
    logic [TIME_BITS-1:0]           since_reg, since_next;
    logic [TIME_BITS-1:0]           held_reg, held_next;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;

    logic                           s_fire;
    logic [1:0]                     ab;
    logic                           btn_down;
    logic                           tick;
    logic                           query;
    logic [TIME_BITS-1:0]           since_t;
    logic [TIME_BITS-1:0]           held_t;
    logic signed [1:0]              delta;
    logic signed [BALANCE_BITS:0]   bal_sum;
    logic signed [BALANCE_BITS:0]   bal_sat;
    logic signed [BALANCE_BITS:0]   bal_step;
    logic [4:0]                     spd;
    logic signed [BALANCE_BITS:0]   spd_ext;
    logic                           accepted;
    reed_pkg::event_t               ev;

    // The output register frees up either when empty or when its result leaves now.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign ab       = {s_tdata[reed_pkg::IN_PIN_A], s_tdata[reed_pkg::IN_PIN_B]};
    assign btn_down = !s_tdata[reed_pkg::IN_BUTTON];
    assign tick     = s_tdata[reed_pkg::IN_TICK];
    assign query    = s_tdata[reed_pkg::IN_QUERY];

    // A detent size of zero behaves as one.
    assign spd     = (steps_reg == 5'd0) ? 5'd1 : steps_reg;
    assign spd_ext = $signed({{(BALANCE_BITS-4){1'b0}}, spd});

    always_comb begin
        // Millisecond counters advance first and stop at full scale.
        since_t = since_reg;
        held_t  = held_reg;
        if (tick) begin
            if (since_reg != TIME_MAX) since_t = since_reg + 1'b1;
            if (held_reg != TIME_MAX)  held_t  = held_reg + 1'b1;
        end

        // Quadrature step into the balance, clamped to its signed range. The very
        // first sample after reset only loads the pin pair.
        delta   = reed_pkg::quad_delta({prev_ab_reg, ab});
        bal_sum = {balance_reg[BALANCE_BITS-1], balance_reg}
                  + {{(BALANCE_BITS-1){delta[1]}}, delta};
        if (bal_sum > BAL_MAX) begin
            bal_sat = BAL_MAX;
        end else if (bal_sum < BAL_MIN) begin
            bal_sat = BAL_MIN;
        end else begin
            bal_sat = bal_sum;
        end
        bal_step = ab_loaded_reg ? bal_sat : {balance_reg[BALANCE_BITS-1], balance_reg};

        raw_prev_next = raw_prev_reg;
        stable_next   = stable_reg;
        since_next    = since_t;
        held_next     = held_t;
        accepted      = 1'b0;
        ev            = reed_pkg::EV_NONE;
        balance_next  = bal_step[BALANCE_BITS-1:0];

        if (query) begin
            // A raw level change restarts the debounce window.
            if (btn_down != raw_prev_reg) begin
                raw_prev_next = btn_down;
                since_next    = '0;
            end
            if (btn_down != stable_reg &&
                CMP_W'(since_next) >= CMP_W'(debounce_reg)) begin
                accepted    = 1'b1;
                stable_next = btn_down;
                if (btn_down) begin
                    held_next = '0;
                end else if (CMP_W'(held_t) >= CMP_W'(long_press_reg)) begin
                    ev = reed_pkg::EV_LONG;
                end else begin
                    ev = reed_pkg::EV_SHORT;
                end
            end
            // Rotation is reported only when the button did not change this query.
            if (!accepted) begin
                if (bal_step >= spd_ext) begin
                    ev           = reed_pkg::EV_CW;
                    balance_next = BALANCE_BITS'(bal_step - spd_ext);
                end else if (bal_step <= -spd_ext) begin
                    ev           = reed_pkg::EV_CCW;
                    balance_next = BALANCE_BITS'(bal_step + spd_ext);
                end
            end
        end

        prev_ab_next   = ab;
        ab_loaded_next = 1'b1;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, stable_next, ev};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= reed_pkg::DEBOUNCE_RST;
            long_press_reg <= reed_pkg::LONG_PRESS_RST;
            steps_reg      <= reed_pkg::STEPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                reed_pkg::CFG_DEBOUNCE_MS:      debounce_reg   <= cfg_wdata[9:0];
                reed_pkg::CFG_LONG_PRESS_MS:    long_press_reg <= cfg_wdata[15:0];
                reed_pkg::CFG_STEPS_PER_DETENT: steps_reg      <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_ab_reg   <= '0;
            ab_loaded_reg <= 1'b0;
            balance_reg   <= '0;
            raw_prev_reg  <= 1'b0;
            stable_reg    <= 1'b0;
            since_reg     <= '0;
            held_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_fire) begin
                prev_ab_reg   <= prev_ab_next;
                ab_loaded_reg <= ab_loaded_next;
                balance_reg   <= balance_next;
                raw_prev_reg  <= raw_prev_next;
                stable_reg    <= stable_next;
                since_reg     <= since_next;
                held_reg      <= held_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

FILE: hdl/reed_checker.sv
// Port-level checks for the rotary encoder event decoder, bound to its top level.
// Depends on reed_pkg for the event codes.
`timescale 1ns / 1ps

module reed_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // No request is taken while an untaken result blocks the output register.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request accepted over a stalled result");

    // Every accepted request shows a result on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // Without a query nothing is reported.
    a_no_query_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tdata[4] |=> m_tdata[2:0] == 3'(reed_pkg::EV_NONE))
        else $error("event reported without a query");

    // Results carry a defined code and clean padding.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= 3'(reed_pkg::EV_LONG) && m_tdata[7:4] == 4'b0000)
        else $error("undefined event code or padding");

endmodule

bind rotary_encoder_event_decoder reed_checker u_reed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/encoder_event_checker.sv
// Checker for the rotary encoder event decoder: predicts one result per accepted request.
// Watches the input, result and register-write ports; depends on reed_pkg.
`timescale 1ns / 1ps

module encoder_event_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // pin_a, pin_b, button_level, ms_tick, query
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [7:0]                       m_tdata,  // event_code[2:0], button_held
    input  logic                             cfg_wr_en,
    input  logic [reed_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [reed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatch_count,
    output int                               pending_count
);
    import reed_pkg::*;

    typedef struct packed {
        event_t code;
        logic   held;
    } outcome_t;

    localparam int          BAL_HI    = 127;
    localparam int          BAL_LO    = -128;
    localparam logic [15:0] TIME_CEIL = 16'hFFFF;

    logic [9:0]  debounce_ms;
    logic [15:0] long_press_ms;
    logic [4:0]  steps_per_detent;

    logic [1:0]  last_ab;
    logic        ab_seen;
    int          balance;
    logic        raw_last;
    logic        pressed;
    logic [15:0] since_change;
    logic [15:0] held_ms;

    outcome_t    expected_events[$];
    outcome_t    predicted;
    outcome_t    oldest;

    task automatic report_mismatch(input string what);
        $display("[%0t] encoder event mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Quadrature step from the Gray positions of the two pairs: one position
    // back is a positive count, one forward a negative one, anything else none.
    function automatic int quad_step(input logic [1:0] from_ab, input logic [1:0] to_ab);
        logic [1:0] diff;
        diff = {to_ab[1], ^to_ab} - {from_ab[1], ^from_ab};
        case (diff)
            2'd3:    return 1;
            2'd1:    return -1;
            default: return 0;
        endcase
    endfunction

    task automatic reset_model();
        debounce_ms      = DEBOUNCE_RST;
        long_press_ms    = LONG_PRESS_RST;
        steps_per_detent = STEPS_RST;
        last_ab          = 2'b00;
        ab_seen          = 1'b0;
        balance          = 0;
        raw_last         = 1'b0;
        pressed          = 1'b0;
        since_change     = '0;
        held_ms          = '0;
    endtask

    task automatic decode_request(input logic [7:0] req, output outcome_t res);
        logic [1:0] ab;
        logic       raw;
        logic       accepted;
        int         spd;
        event_t     ev;
        ab       = {req[IN_PIN_A], req[IN_PIN_B]};
        raw      = !req[IN_BUTTON];
        accepted = 1'b0;
        ev       = EV_NONE;

        if (req[IN_TICK]) begin
            if (since_change != TIME_CEIL) since_change++;
            if (held_ms != TIME_CEIL) held_ms++;
        end

        if (!ab_seen) begin
            ab_seen = 1'b1;
        end else begin
            balance = balance + quad_step(last_ab, ab);
            if (balance > BAL_HI) balance = BAL_HI;
            if (balance < BAL_LO) balance = BAL_LO;
        end
        last_ab = ab;

        if (req[IN_QUERY]) begin
            if (raw != raw_last) begin
                raw_last     = raw;
                since_change = '0;
            end
            if (raw != pressed && since_change >= debounce_ms) begin
                accepted = 1'b1;
                pressed  = raw;
                if (raw) begin
                    held_ms = '0;
                end else begin
                    ev = (held_ms >= long_press_ms) ? EV_LONG : EV_SHORT;
                end
            end
            if (!accepted) begin
                spd = (steps_per_detent == 0) ? 1 : int'(steps_per_detent);
                if (balance >= spd) begin
                    ev      = EV_CW;
                    balance = balance - spd;
                end else if (balance <= -spd) begin
                    ev      = EV_CCW;
                    balance = balance + spd;
                end
            end
        end

        res.code = ev;
        res.held = pressed;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            expected_events.delete();
            mismatch_count = 0;
        end else begin
            // Results are retired before the request of this edge is predicted.
            if (m_tvalid && m_tready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with nothing expected", m_tdata));
                end else begin
                    oldest = expected_events.pop_front();
                    if (m_tdata[2:0] !== oldest.code)
                        report_mismatch($sformatf("event_code %0d, expected %0d",
                                                  m_tdata[2:0], oldest.code));
                    if (m_tdata[3] !== oldest.held)
                        report_mismatch($sformatf("button_held %0b, expected %0b",
                                                  m_tdata[3], oldest.held));
                end
            end
            if (s_tvalid && s_tready) begin
                decode_request(s_tdata, predicted);
                expected_events.push_back(predicted);
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DEBOUNCE_MS:      debounce_ms      = cfg_wdata[9:0];
                    CFG_LONG_PRESS_MS:    long_press_ms    = cfg_wdata[15:0];
                    CFG_STEPS_PER_DETENT: steps_per_detent = cfg_wdata[4:0];
                    default: ;
                endcase
            end
        end
        pending_count = expected_events.size();
    end

endmodule

FILE: tb/rotary_encoder_event_decoder_test.sv
// Top of the rotary encoder event decoder testbench: clock, reset, stimulus and verdict.
// Depends on reed_pkg, the decoder RTL and encoder_event_checker.
`timescale 1ns / 1ps

module rotary_encoder_event_decoder_test;
    import reed_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // pin_a, pin_b, button_level, ms_tick, query
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;   // event_code[2:0], button_held
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatch_count;
    int pending_count;

    // Traffic shaping shared by the request and result sides. When no_idle is set
    // neither side inserts gaps; hold_off_req asks the result side for one long stall.
    bit no_idle;
    bit hold_off_req;
    int stall_left;

    // Encoder position in Gray order and the raw button level driven on the pins.
    logic [1:0] enc_pos;
    int         enc_dir;
    logic       btn_level;

    always #5 aclk = ~aclk;

    rotary_encoder_event_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    encoder_event_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Idle lengths: in most picks a short gap, now and then a long pause.
    function automatic int pick_idle_len();
        if ($urandom_range(99) < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one request after an optional gap and returns at the edge that
    // accepts it. Inputs only change at the falling edge.
    task automatic send_item(input logic a, input logic b, input logic btn,
                             input logic tick, input logic qry);
        logic [7:0] word;
        int         gap;
        word            = '0;
        word[IN_PIN_A]  = a;
        word[IN_PIN_B]  = b;
        word[IN_BUTTON] = btn;
        word[IN_TICK]   = tick;
        word[IN_QUERY]  = qry;
        gap = (no_idle || $urandom_range(99) < 65) ? 0 : pick_idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sends the current encoder position; the pins carry its Gray code.
    task automatic send_position(input logic btn, input logic tick, input logic qry);
        logic [1:0] ab;
        ab = enc_pos ^ (enc_pos >> 1);
        send_item(ab[1], ab[0], btn, tick, qry);
    endtask

    // Drops the request valid and waits until every result has come back, so
    // that register writes only happen while the block is idle.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] deb, input logic [15:0] lng, input logic [15:0] spd);
        write_reg(CFG_DEBOUNCE_MS, deb);
        write_reg(CFG_LONG_PRESS_MS, lng);
        write_reg(CFG_STEPS_PER_DETENT, spd);
    endtask

    // Directed opening: first sample, a full detent each way, an illegal jump,
    // a press that is not yet debounced, press and release with rotation
    // suppressed, long and short presses, and the zero detent size.
    task automatic run_directed();
        send_item(1, 1, 1, 1, 1);   // first sample after reset only loads AB
        send_item(0, 1, 1, 0, 0);   // one clockwise detent from 11
        send_item(0, 0, 1, 1, 0);
        send_item(1, 0, 1, 0, 0);
        send_item(1, 1, 1, 0, 1);
        send_item(1, 0, 1, 0, 0);   // and back counterclockwise
        send_item(0, 0, 1, 1, 0);
        send_item(0, 1, 1, 0, 0);
        send_item(1, 1, 1, 0, 1);
        send_item(0, 0, 1, 0, 1);   // both pins flip at once: no count
        send_item(0, 0, 0, 1, 1);   // press seen, but 50 ms have not passed

        configure(16'd0, 16'd3, 16'd0);
        send_item(1, 0, 0, 0, 0);
        send_item(1, 1, 0, 0, 1);   // press accepted, pending rotation held back
        send_item(1, 1, 0, 1, 1);   // now the rotation comes out
        send_item(1, 1, 0, 1, 0);
        send_item(1, 1, 0, 1, 0);
        send_item(1, 1, 1, 0, 1);   // release after three ms: long press
        send_item(1, 1, 0, 0, 1);
        send_item(1, 1, 1, 1, 1);   // release after one ms: short press
        send_item(0, 1, 1, 0, 1);
        send_item(0, 0, 1, 0, 1);
        enc_pos = 2'd0;
        btn_level = 1'b1;
    endtask

    // Mostly plausible encoder motion and button activity with random ticks and
    // queries; the rest is raw noise on all pins.
    task automatic random_items(input int count);
        logic [4:0] noise;
        repeat (count) begin
            if ($urandom_range(99) < 15) begin
                noise = 5'($urandom_range(0, 31));
                send_item(noise[0], noise[1], noise[2], noise[3], noise[4]);
                enc_pos   = {noise[0], noise[0] ^ noise[1]};
                btn_level = noise[2];
            end else begin
                if ($urandom_range(99) < 8) enc_dir = -enc_dir;
                if ($urandom_range(99) < 55) enc_pos = enc_pos + 2'(enc_dir);
                if ($urandom_range(999) < 15) btn_level = ~btn_level;
                send_position(btn_level, $urandom_range(99) < 60, $urandom_range(99) < 30);
            end
        end
    endtask

    // Saturation of the detent balance at both ends, with a release that is
    // still waiting for its debounce so rotation keeps being evaluated.
    task automatic run_saturation();
        configure(16'd0, 16'd65535, 16'd31);
        send_position(1'b1, 1'b0, 1'b1);
        send_position(1'b0, 1'b0, 1'b1);   // press accepted, held time restarts
        write_reg(CFG_DEBOUNCE_MS, 16'd1023);
        send_position(1'b1, 1'b0, 1'b1);   // release seen but not yet debounced
        no_idle = 1'b1;
        repeat (140) begin
            enc_pos = enc_pos - 2'd1;
            send_position(1'b1, $urandom_range(1), 1'b0);
        end
        repeat (6) send_position(1'b1, 1'b0, 1'b1);
        repeat (270) begin
            enc_pos = enc_pos + 2'd1;
            send_position(1'b1, $urandom_range(1), 1'b0);
        end
        repeat (8) send_position(1'b1, 1'b0, 1'b1);
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, or one long stall when the stimulus asks,
    // counted here while requests keep coming so the block backs up.
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = 300;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(99) < 20) stall_left = pick_idle_len();
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        enc_pos   = 2'd0;
        enc_dir   = 1;
        btn_level = 1'b1;
        no_idle   = 1'b0;
        hold_off_req = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();

        configure(16'd0, 16'd0, 16'd0);
        random_items(160);
        configure(16'd3, 16'd25, 16'd1);
        random_items(160);
        run_saturation();
        random_items(100);
        configure(16'd10, 16'd60, 16'd16);
        random_items(160);
        no_idle = 1'b1;
        configure(16'd2, 16'd8, 16'd2);
        random_items(130);
        no_idle = 1'b0;
        configure(16'd1, 16'd500, 16'd17);
        random_items(100);
        configure(16'd20, 16'd40, 16'd4);
        random_items(40);
        hold_off_req = 1'b1;
        random_items(150);

        settle();
        repeat (10) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("rotary_encoder_event_decoder verification clean");
        end else begin
            $display("rotary_encoder_event_decoder verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("rotary_encoder_event_decoder verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/reed_pkg.sv
hdl/rotary_encoder_event_decoder.sv
hdl/reed_checker.sv
tb/encoder_event_checker.sv
tb/rotary_encoder_event_decoder_test.sv
